// ===== design/lstm_peephole_cell_step_assert.svh =====
// assertion macros shared by the lstm peephole cell step rtl
// expects clk and arst_n in the scope of each use
`ifndef LSTM_PEEPHOLE_CELL_STEP_ASSERT_SVH
`define LSTM_PEEPHOLE_CELL_STEP_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define LPC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define LPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/lpc_pkg.sv =====
// types, constants and helper functions for the lstm peephole cell step
// no dependencies; used by every module of the block
package lpc_pkg;

	// number format: signed q4.12, sigmoid offset mapping assumes DATA_W == FRAC_W + 4
	localparam int DATA_W     = 16;
	localparam int FRAC_W     = 12;
	localparam int ONE        = 1 << FRAC_W;
	localparam int TAB_DEPTH  = 256;
	localparam int SEG_IDX_W  = $clog2(TAB_DEPTH);
	localparam int TAB_IDX_W  = SEG_IDX_W + 1;
	localparam int FRAC_LO_W  = DATA_W - SEG_IDX_W;
	localparam int SIG_W      = FRAC_W + 1;
	localparam int TG_W       = SIG_W + 2;
	localparam int WIDE_W     = 40;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int LAT        = 10;

	localparam logic signed [WIDE_W-1:0] WIDE_MAX  = WIDE_W'((1 << (DATA_W - 1)) - 1);
	localparam logic signed [WIDE_W-1:0] WIDE_MIN  = -WIDE_MAX - WIDE_W'(1);
	localparam logic signed [WIDE_W-1:0] WIDE_HALF = WIDE_W'(1 << (FRAC_W - 1));

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IG_BIAS,
		REG_FG_BIAS,
		REG_OG_BIAS,
		REG_CAND_BIAS,
		REG_IG_PEEP,
		REG_FG_PEEP,
		REG_OG_PEEP
	} cfg_idx_t;

	// configuration as seen by the datapath
	typedef struct packed {
		logic signed [CFG_W-1:0] ig_bias;
		logic signed [CFG_W-1:0] fg_bias;
		logic signed [CFG_W-1:0] og_bias;
		logic signed [CFG_W-1:0] cand_bias;
		logic signed [CFG_W-1:0] ig_peep;
		logic signed [CFG_W-1:0] fg_peep;
		logic signed [CFG_W-1:0] og_peep;
	} cfg_t;

	typedef logic [SIG_W-1:0] sig_tab_t [0:TAB_DEPTH];

	// unsigned shift and subtract quotient, only used while building the table
	function automatic longint unsigned udiv64(
		input longint unsigned num,
		input longint unsigned den
	);
		longint unsigned q, r;
		q = 0;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= den) begin
				r = r - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// sigmoid samples over [-8, 8], one extra end sample for the last segment
	function automatic sig_tab_t build_sig_tab();
		sig_tab_t tab;
		longint d;
		longint unsigned a, v31, e, term, den, neg;
		longint sum;
		for (int k = 0; k <= TAB_DEPTH; k++) begin
			d = 2 * longint'(k) - longint'(TAB_DEPTH);
			a = unsigned'((d < 0) ? -d : d);
			v31 = (a << 30) >> SEG_IDX_W;
			sum = 64'h8000_0000;
			term = 64'h8000_0000;
			// exp(-v) by taylor series, each term floored
			for (int n = 1; n <= 16; n++) begin
				term = udiv64((term * v31) >> 31, 64'(n));
				if ((n & 1) == 1)
					sum = sum - signed'(term);
				else
					sum = sum + signed'(term);
			end
			if (sum < 0)
				sum = 0;
			if (sum > 64'sh8000_0000)
				sum = 64'sh8000_0000;
			e = unsigned'(sum);
			// raise to the sixteenth power
			for (int s = 0; s < 4; s++)
				e = (e * e) >> 31;
			den = 64'h8000_0000 + e;
			neg = udiv64((e << FRAC_W) + (den >> 1), den);
			tab[k] = (d < 0) ? SIG_W'(neg) : SIG_W'(64'(ONE) - neg);
		end
		return tab;
	endfunction

	localparam sig_tab_t SIG_TAB = build_sig_tab();

	// saturate a wide value to the data range
	function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [WIDE_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > WIDE_MAX)
			r = WIDE_MAX[DATA_W-1:0];
		else if (v < WIDE_MIN)
			r = WIDE_MIN[DATA_W-1:0];
		else
			r = v[DATA_W-1:0];
		return r;
	endfunction

	// round half up and drop the fraction bits of a product
	function automatic logic signed [WIDE_W-1:0] rnd_fx(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] r;
		r = (v + WIDE_HALF) >>> FRAC_W;
		return r;
	endfunction

	// gate argument: sum + bias + rounded peephole product, saturated
	function automatic logic signed [DATA_W-1:0] gate_arg(
		input logic signed [DATA_W-1:0]   sum,
		input logic signed [CFG_W-1:0]    bias,
		input logic signed [2*DATA_W-1:0] prod
	);
		logic signed [WIDE_W-1:0] acc;
		acc = WIDE_W'(sum) + WIDE_W'(bias) + rnd_fx(WIDE_W'(prod));
		return sat_data(acc);
	endfunction

	// doubled argument for tanh, clamped to the data range
	function automatic logic signed [DATA_W-1:0] dbl_sat(input logic signed [DATA_W-1:0] x);
		logic signed [DATA_W-1:0] r;
		if (x[DATA_W-1] != x[DATA_W-2])
			r = x[DATA_W-1] ? WIDE_MIN[DATA_W-1:0] : WIDE_MAX[DATA_W-1:0];
		else
			r = {x[DATA_W-2:0], 1'b0};
		return r;
	endfunction

	// tanh from sigmoid of the doubled argument: 2*s - 1
	function automatic logic signed [TG_W-1:0] tanh_post(input logic [SIG_W-1:0] s);
		logic signed [TG_W-1:0] r;
		r = signed'({1'b0, s, 1'b0}) - TG_W'(ONE);
		return r;
	endfunction

endpackage

// ===== design/lstm_peephole_cell_step.sv =====
// top level of the lstm peephole cell step: ten-stage streaming datapath
// depends on lpc_pkg, lpc_cfg_regs, lpc_sigmoid and the assertion header
//
// Usage:
//   request channel: start with the five input sums; a request is taken at a
//   rising edge with start high and busy low. busy is high during reset and up
//   to the first rising edge after it, so one request may be taken in every cycle.
//   result channel: done strobes for one cycle with hidden_out and new_cell;
//   the receiver cannot stall, so the pipeline never holds.
//   configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; write only
//   while no request is in flight. Indexes beyond the register list are ignored.
// Timing:
//   throughput one request per cycle. The depth of the pipe from request to done is
//   set by the two chained sigmoid units (two stages each) and the multiply stages
//   around them.
// Reset:
//   arst_n clears the valid pipe and loads the register defaults (biases 1.0,
//   peephole weights 0); requests in flight are dropped.
`include "lstm_peephole_cell_step_assert.svh"

module lstm_peephole_cell_step (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [lpc_pkg::DATA_W-1:0] candidate_sum,
	input  logic signed [lpc_pkg::DATA_W-1:0] input_gate_sum,
	input  logic signed [lpc_pkg::DATA_W-1:0] output_gate_sum,
	input  logic signed [lpc_pkg::DATA_W-1:0] forget_gate_sum,
	input  logic signed [lpc_pkg::DATA_W-1:0] previous_cell,
	output logic                              done,
	output logic signed [lpc_pkg::DATA_W-1:0] hidden_out,
	output logic signed [lpc_pkg::DATA_W-1:0] new_cell,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lpc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lpc_pkg::CFG_W-1:0]         cfg_data
);
	import lpc_pkg::*;

	localparam int PIG_W = SIG_W + 1 + TG_W;
	localparam int PFG_W = SIG_W + 1 + DATA_W;

	cfg_t cfg;
	logic busy_q;
	logic acc;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;

	logic signed [2*DATA_W-1:0] prod_ig_s1, prod_fg_s1, prod_og_s1;
	logic signed [DATA_W-1:0]   ig_sum_s1, fg_sum_s1, og_sum_s1, cand_arg_s1;
	logic signed [DATA_W-1:0]   prev_s1, prev_s2, prev_s3, prev_s4;
	logic signed [DATA_W-1:0]   ig_arg_s2, fg_arg_s2, og_arg_s2, targ_s2;
	logic [SIG_W-1:0]           ig_sig, fg_sig, og_sig, cs_sig, cs2_sig;
	logic signed [PIG_W-1:0]    p_ig_s5;
	logic signed [PFG_W-1:0]    p_fg_s5;
	logic [SIG_W-1:0]           og_s5, og_s6, og_s7, og_s8;
	logic signed [WIDE_W-1:0]   cell_acc;
	logic signed [DATA_W-1:0]   cell_c;
	logic signed [DATA_W-1:0]   cell_s6, cell_s7, cell_s8, cell_s9, cell_s10;
	logic signed [DATA_W-1:0]   cell_targ_s6;
	logic signed [PIG_W-1:0]    p_h_s9;
	logic signed [DATA_W-1:0]   hidden_s10;

	// busy is set by reset and cleared at the first clock edge once reset is released
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			busy_q <= 1'b1;
		else
			busy_q <= 1'b0;
	end

	assign busy      = busy_q;
	assign cfg_ready = !busy_q;
	assign acc       = start && !busy_q;

	// configuration registers
	lpc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// valid pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else begin
			vld_s1  <= acc;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	// stage 1: peephole products and candidate argument
	always_ff @(posedge clk) begin
		prod_ig_s1  <= cfg.ig_peep * previous_cell;
		prod_fg_s1  <= cfg.fg_peep * previous_cell;
		prod_og_s1  <= cfg.og_peep * previous_cell;
		ig_sum_s1   <= input_gate_sum;
		fg_sum_s1   <= forget_gate_sum;
		og_sum_s1   <= output_gate_sum;
		cand_arg_s1 <= sat_data(WIDE_W'(candidate_sum) + WIDE_W'(cfg.cand_bias));
		prev_s1     <= previous_cell;
	end

	// stage 2: gate arguments and doubled candidate argument
	always_ff @(posedge clk) begin
		ig_arg_s2 <= gate_arg(ig_sum_s1, cfg.ig_bias, prod_ig_s1);
		fg_arg_s2 <= gate_arg(fg_sum_s1, cfg.fg_bias, prod_fg_s1);
		og_arg_s2 <= gate_arg(og_sum_s1, cfg.og_bias, prod_og_s1);
		targ_s2   <= dbl_sat(cand_arg_s1);
		prev_s2   <= prev_s1;
	end

	// stages 3 and 4: gate and candidate sigmoids
	lpc_sigmoid u_sig_ig (.clk(clk), .x(ig_arg_s2), .y(ig_sig));
	lpc_sigmoid u_sig_fg (.clk(clk), .x(fg_arg_s2), .y(fg_sig));
	lpc_sigmoid u_sig_og (.clk(clk), .x(og_arg_s2), .y(og_sig));
	lpc_sigmoid u_sig_cs (.clk(clk), .x(targ_s2),   .y(cs_sig));

	always_ff @(posedge clk) begin
		prev_s3 <= prev_s2;
		prev_s4 <= prev_s3;
	end

	// stage 5: i*g and f*prev
	always_ff @(posedge clk) begin
		p_ig_s5 <= signed'({1'b0, ig_sig}) * tanh_post(cs_sig);
		p_fg_s5 <= signed'({1'b0, fg_sig}) * prev_s4;
		og_s5   <= og_sig;
	end

	// stage 6: new cell with one rounding, then doubled for tanh
	assign cell_acc = WIDE_W'(p_ig_s5) + WIDE_W'(p_fg_s5);
	assign cell_c   = sat_data(rnd_fx(cell_acc));

	always_ff @(posedge clk) begin
		cell_s6      <= cell_c;
		cell_targ_s6 <= dbl_sat(cell_c);
		og_s6        <= og_s5;
	end

	// stages 7 and 8: tanh of the new cell
	lpc_sigmoid u_sig_cell (.clk(clk), .x(cell_targ_s6), .y(cs2_sig));

	always_ff @(posedge clk) begin
		cell_s7 <= cell_s6;
		cell_s8 <= cell_s7;
		og_s7   <= og_s6;
		og_s8   <= og_s7;
	end

	// stage 9: o * tanh(cell)
	always_ff @(posedge clk) begin
		p_h_s9  <= signed'({1'b0, og_s8}) * tanh_post(cs2_sig);
		cell_s9 <= cell_s8;
	end

	// stage 10: round and saturate the output
	always_ff @(posedge clk) begin
		hidden_s10 <= sat_data(rnd_fx(WIDE_W'(p_h_s9)));
		cell_s10   <= cell_s9;
	end

	assign done       = vld_s10;
	assign hidden_out = hidden_s10;
	assign new_cell   = cell_s10;

	// checks
	`LPC_ASSERT_IMPL(a_done_has_request, done, $past(start && !busy, LAT), "result without request")
	`LPC_ASSERT_IMPL(a_gate_in_range, vld_s4, (ig_sig <= SIG_W'(ONE)) && (fg_sig <= SIG_W'(ONE)) && (og_sig <= SIG_W'(ONE)), "gate above one")
	`LPC_ASSERT_NEXT(a_busy_low_after_reset, 1'b1, !busy, "busy outside reset")

endmodule

// ===== design/lpc_sigmoid.sv =====
// two-stage sigmoid unit: table lookup, then linear interpolation
// depends on lpc_pkg for the sample table and widths
module lpc_sigmoid (
	input  logic                              clk,
	input  logic signed [lpc_pkg::DATA_W-1:0] x,
	output logic        [lpc_pkg::SIG_W-1:0]  y
);
	import lpc_pkg::*;

	localparam int PROD_W = SIG_W + FRAC_LO_W + 2;
	localparam logic signed [PROD_W-1:0] ROUND_C = PROD_W'(1 << (FRAC_LO_W - 1));

	logic [DATA_W-1:0]    off;
	logic [TAB_IDX_W-1:0] idx;
	logic [SIG_W-1:0]     t_lo_s1;
	logic [SIG_W-1:0]     t_hi_s1;
	logic [FRAC_LO_W-1:0] rem_s1;
	logic signed [SIG_W:0]    diff;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] corr;
	logic [SIG_W-1:0]     y_s2;

	// offset from the bottom of the table: flipping the sign bit adds 8.0
	assign off = {~x[DATA_W-1], x[DATA_W-2:0]};
	assign idx = {1'b0, off[DATA_W-1 -: SEG_IDX_W]};

	// segment end samples and position inside the segment
	always_ff @(posedge clk) begin
		t_lo_s1 <= SIG_TAB[idx];
		t_hi_s1 <= SIG_TAB[idx + TAB_IDX_W'(1)];
		rem_s1  <= off[FRAC_LO_W-1:0];
	end

	// interpolation with round half up
	assign diff = signed'({1'b0, t_hi_s1}) - signed'({1'b0, t_lo_s1});
	assign prod = diff * signed'({1'b0, rem_s1});
	assign corr = (prod + ROUND_C) >>> FRAC_LO_W;

	always_ff @(posedge clk) begin
		y_s2 <= t_lo_s1 + corr[SIG_W-1:0];
	end

	assign y = y_s2;

endmodule

// ===== design/lpc_cfg_regs.sv =====
// configuration registers: biases and peephole weights
// depends on lpc_pkg for the register indexes and the cfg_t struct
`include "lstm_peephole_cell_step_assert.svh"

module lpc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr,
	input  logic [lpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lpc_pkg::CFG_W-1:0]      cfg_data,
	output lpc_pkg::cfg_t                  cfg
);
	import lpc_pkg::*;

	cfg_t cfg_q;

	// register write decode, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ig_bias   <= CFG_W'(ONE);
			cfg_q.fg_bias   <= CFG_W'(ONE);
			cfg_q.og_bias   <= CFG_W'(ONE);
			cfg_q.cand_bias <= CFG_W'(ONE);
			cfg_q.ig_peep   <= '0;
			cfg_q.fg_peep   <= '0;
			cfg_q.og_peep   <= '0;
		end else if (wr) begin
			unique case (cfg_index)
				REG_IG_BIAS:   cfg_q.ig_bias   <= cfg_data;
				REG_FG_BIAS:   cfg_q.fg_bias   <= cfg_data;
				REG_OG_BIAS:   cfg_q.og_bias   <= cfg_data;
				REG_CAND_BIAS: cfg_q.cand_bias <= cfg_data;
				REG_IG_PEEP:   cfg_q.ig_peep   <= cfg_data;
				REG_FG_PEEP:   cfg_q.fg_peep   <= cfg_data;
				REG_OG_PEEP:   cfg_q.og_peep   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

	// checks
	`LPC_ASSERT_NEXT(a_cfg_write_lands, wr && cfg_index == REG_IG_PEEP, cfg.ig_peep == $past(cfg_data), "peephole weight write lost")

endmodule
